// File: rtl/core/rgb_to_escaped_sixbit_text_unit_macros.svh
// Assertion macros used by the six-bit text encoder RTL.
`ifndef RGB_TO_ESCAPED_SIXBIT_TEXT_UNIT_MACROS_SVH
`define RGB_TO_ESCAPED_SIXBIT_TEXT_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Checked property, quiet while in reset.
`define RTE_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
// Checked property, active in reset as well.
`define RTE_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define RTE_ASSERT(lbl, ck, rs, prop, msg)
`define RTE_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif

`endif

// File: rtl/core/rte_pkg.sv
// Types and constants for the six-bit escaped text encoder.
`timescale 1ns / 1ps

package rte_pkg;

  localparam int unsigned MaxBytes = 12;
  localparam int unsigned CountW   = 4;
  localparam int unsigned GroupW   = 6;
  localparam int unsigned Groups   = 4;

  localparam logic [7:0] CharOffset    = 8'd33;
  localparam logic [7:0] QuoteChar     = 8'd34;
  localparam logic [7:0] BackslashChar = 8'd92;
  localparam logic [7:0] NewlineChar   = 8'd10;
  localparam logic [7:0] TabChar       = 8'd9;
  localparam logic [7:0] DefaultLine   = 8'd16;
  localparam logic [CountW-1:0] MinBytes = CountW'(4);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_of_pixel;
  } text_t;

  typedef logic [MaxBytes-1:0][7:0] byte_list_t;

  // Expanded byte sequence of one pixel request.
  typedef struct packed {
    byte_list_t        bytes;
    logic [CountW-1:0] count;
  } enc_t;

endpackage

// File: rtl/core/rgb_to_escaped_sixbit_text_unit.sv
// Top level: pixel to escaped six-bit printable text encoder.
// A taken pixel passes the input register, then the result register, before its first byte is offered.
// Throughput: one byte per cycle while out_stall is low; a pixel gives 4 to 12 bytes
//   (4 bytes, one more per escape, 4 more for a line break).
// A new pixel is taken while the previous one drains. Synchronous reset empties
//   both registers, clears the line count and sets the line length to 16.
`timescale 1ns / 1ps

module rgb_to_escaped_sixbit_text_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [7:0]      cfg_wr_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  rte_pkg::pixel_t in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output rte_pkg::text_t  out_data
);

  logic            in_full;
  logic            in_full_next;
  rte_pkg::pixel_t pixel;
  logic [7:0]      pixels_per_line;
  logic [7:0]      pixels_on_line;
  logic [7:0]      pixels_on_line_next;
  logic [8:0]      count_inc;
  logic            line_break;
  logic            emit_ready;
  logic            move;
  logic            in_take;
  rte_pkg::enc_t   enc;

  assign in_stall = in_full && !emit_ready;
  assign in_take  = in_valid && !in_stall;
  assign move     = in_full && emit_ready;

  assign count_inc  = {1'b0, pixels_on_line} + 9'd1;
  assign line_break = (count_inc >= {1'b0, pixels_per_line});

  always_comb begin
    in_full_next = in_full;
    if (in_take) begin
      in_full_next = 1'b1;
    end else if (move) begin
      in_full_next = 1'b0;
    end
    pixels_on_line_next = pixels_on_line;
    if (move) begin
      pixels_on_line_next = line_break ? 8'd0 : count_inc[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full         <= 1'b0;
      pixels_on_line  <= '0;
      pixels_per_line <= rte_pkg::DefaultLine;
    end else begin
      in_full        <= in_full_next;
      pixels_on_line <= pixels_on_line_next;
      if (cfg_wr_en) begin
        pixels_per_line <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pixel <= in_data;
    end
  end

  rte_encode u_encode (
    .pixel      (pixel),
    .line_break (line_break),
    .enc        (enc)
  );

  rte_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load_valid (in_full),
    .load_ready (emit_ready),
    .load_data  (enc),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// File: rtl/core/rte_encode.sv
// Combinational expansion of one pixel into its escaped byte sequence.
`timescale 1ns / 1ps

module rte_encode (
  input  rte_pkg::pixel_t pixel,
  input  logic            line_break,
  output rte_pkg::enc_t   enc
);

  logic [23:0]                 word;
  logic [rte_pkg::GroupW-1:0]  grp;
  logic [7:0]                  ch;
  logic [rte_pkg::CountW-1:0]  pos;
  rte_pkg::byte_list_t         bytes;

  assign word = {pixel.red, pixel.green, pixel.blue};

  always_comb begin
    bytes = '0;
    pos   = '0;
    grp   = '0;
    ch    = '0;
    for (int g = 0; g < rte_pkg::Groups; g++) begin
      grp = word[23 - rte_pkg::GroupW * g -: rte_pkg::GroupW];
      ch  = {2'b00, grp} + rte_pkg::CharOffset;
      if (ch == rte_pkg::QuoteChar || ch == rte_pkg::BackslashChar) begin
        bytes[pos] = rte_pkg::BackslashChar;
        pos        = pos + 1'b1;
      end
      bytes[pos] = ch;
      pos        = pos + 1'b1;
    end
    if (line_break) begin
      bytes[pos]               = rte_pkg::QuoteChar;
      bytes[pos + 4'd1]        = rte_pkg::NewlineChar;
      bytes[pos + 4'd2]        = rte_pkg::TabChar;
      bytes[pos + 4'd3]        = rte_pkg::QuoteChar;
      pos                      = pos + 4'd4;
    end
  end

  assign enc.bytes = bytes;
  assign enc.count = pos;

endmodule

// File: rtl/core/rte_emit.sv
// Result register and byte serialiser for the output channel.
`timescale 1ns / 1ps
`include "rgb_to_escaped_sixbit_text_unit_macros.svh"

module rte_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                load_valid,
  output logic                load_ready,
  input  rte_pkg::enc_t       load_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rte_pkg::text_t      out_data
);

  logic                       full;
  logic                       full_next;
  rte_pkg::byte_list_t        bytes;
  logic [rte_pkg::CountW-1:0] cnt;
  logic [rte_pkg::CountW-1:0] idx;
  logic                       last;
  logic                       take;
  logic                       load;

  assign last       = (idx == cnt - 1'b1);
  assign take       = full && !out_stall;
  assign load_ready = !full || (take && last);
  assign load       = load_valid && load_ready;

  always_comb begin
    full_next = full;
    if (load) begin
      full_next = 1'b1;
    end else if (take && last) begin
      full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= '0;
    end else begin
      full <= full_next;
      if (load) begin
        idx <= '0;
      end else if (take) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= load_data.bytes;
      cnt   <= load_data.count;
    end
  end

  assign out_valid              = full;
  assign out_data.text_byte     = bytes[idx];
  assign out_data.last_of_pixel = last;

  `RTE_ASSERT(a_count_range, clk, rst,
    full |-> (cnt >= rte_pkg::MinBytes && cnt <= rte_pkg::CountW'(rte_pkg::MaxBytes)),
    "byte count out of range")
  `RTE_ASSERT(a_idx_in_range, clk, rst, full |-> (idx < cnt), "byte index past end")
  `RTE_ASSERT(a_drain, clk, rst, (take && last && !load_valid) |=> !full,
    "result register not freed after last byte")
  `RTE_ASSERT(a_hold_on_stall, clk, rst, (full && out_stall) |=> (full && $stable(idx)),
    "index moved while stalled")
  `RTE_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !full, "not empty after reset")

endmodule

// File: sim/tb_rgb_to_escaped_sixbit_text_unit.sv
// Self-checking testbench for the pixel to escaped six-bit text encoder.
`timescale 1ns / 1ps

module tb_rgb_to_escaped_sixbit_text_unit;

  localparam int unsigned Limit    = 200000;
  localparam int unsigned HoldOff  = 80;
  localparam int unsigned DirRows  = 17;
  localparam logic [5:0] QuoteGroup     = 6'(rte_pkg::QuoteChar - rte_pkg::CharOffset);
  localparam logic [5:0] BackslashGroup = 6'(rte_pkg::BackslashChar - rte_pkg::CharOffset);

  typedef logic [7:0] byte_q_t [$];

  typedef struct packed {
    rte_pkg::pixel_t px;
    logic            typed;
    logic [3:0]      n;
    logic [63:0]     chars;
  } pixel_row_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_wr_en = 1'b0;
  logic [7:0]      cfg_wr_data = 8'd0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  rte_pkg::pixel_t in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  rte_pkg::text_t  out_data;

  rte_pkg::text_t text_due [$];
  logic [7:0]     line_len = rte_pkg::DefaultLine;
  logic [7:0]     line_count = 8'd0;
  int unsigned    faults = 0;
  int unsigned    cycles = 0;
  int unsigned    hold_req = 0;
  int unsigned    hold_seen = 0;
  int unsigned    hold_left = 0;
  bit             quiet = 1'b0;
  pixel_row_t     dir_rows [DirRows];

  rgb_to_escaped_sixbit_text_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= Limit) begin
      $display("rgb_to_escaped_sixbit_text_unit test failed");
      $finish;
    end
  end

  // Appends the bytes of one pixel, with the line break where it falls.
  function automatic void queue_pixel(input byte_q_t body);
    rte_pkg::text_t t;
    if ({1'b0, line_count} + 9'd1 >= {1'b0, line_len}) begin
      body.push_back(rte_pkg::QuoteChar);
      body.push_back(rte_pkg::NewlineChar);
      body.push_back(rte_pkg::TabChar);
      body.push_back(rte_pkg::QuoteChar);
      line_count = 8'd0;
    end else begin
      line_count = line_count + 8'd1;
    end
    for (int i = 0; i < body.size(); i++) begin
      t.text_byte     = body[i];
      t.last_of_pixel = (i == body.size() - 1);
      text_due.push_back(t);
    end
  endfunction

  function automatic void predict_text(input rte_pkg::pixel_t px);
    logic [23:0] word;
    logic [7:0]  ch;
    byte_q_t     body;
    word = px;
    for (int g = 0; g < rte_pkg::Groups; g++) begin
      ch = {2'b00, word[23 - rte_pkg::GroupW * g -: rte_pkg::GroupW]} + rte_pkg::CharOffset;
      if (ch == rte_pkg::QuoteChar || ch == rte_pkg::BackslashChar) begin
        body.push_back(rte_pkg::BackslashChar);
      end
      body.push_back(ch);
    end
    queue_pixel(body);
  endfunction

  // Mostly groups that land on the escaped and end-of-range characters.
  function automatic rte_pkg::pixel_t rand_pixel();
    logic [23:0] word;
    logic [5:0]  grp;
    if ($urandom_range(3) == 0) begin
      return rte_pkg::pixel_t'(24'($urandom));
    end
    for (int g = 0; g < rte_pkg::Groups; g++) begin
      case ($urandom_range(4))
        0: grp = 6'd0;
        1: grp = QuoteGroup;
        2: grp = BackslashGroup;
        3: grp = 6'h3F;
        default: grp = 6'($urandom);
      endcase
      word[23 - rte_pkg::GroupW * g -: rte_pkg::GroupW] = grp;
    end
    return word;
  endfunction

  task automatic push_pixel(input rte_pkg::pixel_t px);
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (text_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_line_len(input logic [7:0] len);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    line_len = len;
  endtask

  task automatic run_pixels(input int unsigned count);
    rte_pkg::pixel_t px;
    repeat (count) begin
      px = rand_pixel();
      push_pixel(px);
      predict_text(px);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (text_due.size() == 0) begin
        faults++;
        if (faults <= 10) begin
          $display("unexpected byte %h last %b", out_data.text_byte, out_data.last_of_pixel);
        end
      end else begin
        if (out_data !== text_due[0]) begin
          faults++;
          if (faults <= 10) begin
            $display("byte mismatch: expected %h last %b, got %h last %b",
                     text_due[0].text_byte, text_due[0].last_of_pixel,
                     out_data.text_byte, out_data.last_of_pixel);
          end
        end
        void'(text_due.pop_front());
      end
    end
  end

  // Receiver side: random idling, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldOff;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 15);
    end
  end

  initial begin
    byte_q_t body;
    dir_rows = '{
      '{24'h000000, 1'b1, 4'd4, 64'h21212121_00000000},
      '{24'hFFFFFF, 1'b1, 4'd4, 64'h60606060_00000000},
      '{24'h041041, 1'b1, 4'd8, 64'h5C225C22_5C225C22},
      '{24'hEFBEFB, 1'b1, 4'd8, 64'h5C5C5C5C_5C5C5C5C},
      '{24'h000001, 1'b1, 4'd5, 64'h2121215C_22000000},
      '{24'h800000, 1'b1, 4'd4, 64'h41212121_00000000},
      '{24'hFF0000, 1'b0, 4'd0, 64'h0},
      '{24'h00FF00, 1'b0, 4'd0, 64'h0},
      '{24'h0000FF, 1'b0, 4'd0, 64'h0},
      '{24'hAAAAAA, 1'b0, 4'd0, 64'h0},
      '{24'h555555, 1'b0, 4'd0, 64'h0},
      '{24'h7DF7DF, 1'b0, 4'd0, 64'h0},
      '{24'h04103B, 1'b0, 4'd0, 64'h0},
      '{24'hFC0000, 1'b0, 4'd0, 64'h0},
      '{24'h03F000, 1'b0, 4'd0, 64'h0},
      '{24'h000FC0, 1'b0, 4'd0, 64'h0},
      '{24'h00003F, 1'b0, 4'd0, 64'h0}
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default line length: break after the sixteenth pixel
    for (int r = 0; r < DirRows; r++) begin
      push_pixel(dir_rows[r].px);
      if (dir_rows[r].typed) begin
        body = {};
        for (int i = 0; i < dir_rows[r].n; i++) begin
          body.push_back(dir_rows[r].chars[63 - 8 * i -: 8]);
        end
        queue_pixel(body);
      end else begin
        predict_text(dir_rows[r].px);
      end
    end

    write_line_len(8'd1);
    run_pixels(2);
    write_line_len(8'd0);
    run_pixels(2);
    // shortened mid-line: break follows the next pixel
    write_line_len(8'd8);
    run_pixels(5);
    write_line_len(8'd2);
    run_pixels(1);

    write_line_len(8'd255);
    run_pixels(15);
    for (int p = 0; p < 4; p++) begin
      write_line_len(8'($urandom_range(8, 1)));
      quiet = (p == 1);
      if (p == 2) hold_req++;
      run_pixels(25);
      quiet = 1'b0;
    end
    write_line_len(8'($urandom_range(255, 1)));
    run_pixels(20);

    in_valid <= 1'b0;
    while (text_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (faults == 0 && text_due.size() == 0) begin
      $display("rgb_to_escaped_sixbit_text_unit test passed");
    end else begin
      $display("rgb_to_escaped_sixbit_text_unit test failed");
    end
    $finish;
  end

endmodule
